// ----- hw/rtl/rmf_pkg.sv -----
// ----------------------------------------------------------------------------
// rmf_pkg - shared types and constants of the rgb 7x7 median filter
// command and status words between controller and datapath, register codes
// ----------------------------------------------------------------------------
package rmf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_HALF_WIDTH = 3;

    localparam int PIX_W        = 8;
    localparam int CH_N         = 3;
    localparam int CFG_W        = 13;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int ROW_OUT_W    = 12;
    localparam int COL_OUT_W    = 10;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 48;
    localparam int EMIT_W       = 3;
    localparam int BIT_W        = 3;

    typedef logic [0:0] t_reg_idx;
    localparam t_reg_idx REG_FRAME_WIDTH  = 1'b0;
    localparam t_reg_idx REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic             push;
        logic             win_start;
        logic             win_step;
        logic             sel_init;
        logic             sel_step;
        logic [BIT_W-1:0] sel_bit;
        logic             emit;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic              frame_pushed;
        logic              out_free;
        logic [EMIT_W-1:0] push_emits;
    } t_sts;

endpackage

// ----- hw/rtl/rgb_median_filter_7x7.sv -----
// ----------------------------------------------------------------------------
// rgb_median_filter_7x7 - per-channel 7x7 median of an rgb raster stream
// replicated borders, line store of seven rows, flush words drain the tail
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    contents
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  pixel word, tuser = flush
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  median pixel and position
//  cfg       in         i_cfg_valid/o_cfg_ready      frame width / frame height
//
//  each output pixel passes through start, TAPS line store reads (49 at 7x7) on
//  the single read port, one capture, 8 bit-selection steps and load; a word
//  causing no output leaves the controller idle, a row-end push gives up to
//  four outputs
//  reset clears counters and sets width 1024, height 4096; no store clearing
//  the output register lets a new word be taken while a result waits
//  a stalled output holds the pipeline in its load step
// ----------------------------------------------------------------------------
module rgb_median_filter_7x7 #(
    parameter int MAX_WIDTH  = rmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rmf_pkg::DEF_MAX_HEIGHT,
    parameter int HALF_WIDTH = rmf_pkg::DEF_HALF_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  rmf_pkg::t_reg_idx             i_cfg_index,
    input  logic [rmf_pkg::CFG_W-1:0]     i_cfg_data,
    // input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [rmf_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                          i_s_axis_tuser,  // action
    // output stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [rmf_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // red_out, green_out, blue_out,
                                                           // out_row_index, out_col_index, pad
    output logic                          o_m_axis_tlast,  // last_of_run
    output logic                          o_m_axis_tuser   // frame_done
);
    localparam int PIX_W = rmf_pkg::PIX_W;

    rmf_pkg::t_cmd cmd;
    rmf_pkg::t_sts sts;

    logic [PIX_W-1:0]              red, green, blue;
    logic [rmf_pkg::ROW_OUT_W-1:0] row;
    logic [rmf_pkg::COL_OUT_W-1:0] col;

    // the user must change registers only while idle; the block does not enforce it, so writes are always taken
    assign o_cfg_ready = 1'b1;

    rmf_ctrl #(
        .HALF_WIDTH (HALF_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_action (i_s_axis_tuser),
        .i_sts       (sts),
        .o_in_ready  (o_s_axis_tready),
        .o_cmd       (cmd)
    );

    // store word keeps red in the top byte
    rmf_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .HALF_WIDTH (HALF_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_pix        ({i_s_axis_tdata[7:0], i_s_axis_tdata[15:8], i_s_axis_tdata[23:16]}),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_red        (red),
        .o_green      (green),
        .o_blue       (blue),
        .o_row        (row),
        .o_col        (col),
        .o_last       (o_m_axis_tlast),
        .o_frame_done (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {2'b00, col, row, blue, green, red};

    // end of frame only ever comes from a flush, which gives a single word
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("frame end word without last flag");

    // a new result is only loaded while the input side is busy
    a_load_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("result loaded while controller idle");

endmodule

// ----- hw/rtl/rmf_ctrl.sv -----
// ----------------------------------------------------------------------------
// rmf_ctrl - sequencing controller of the median filter
// accepts words, then per output pixel: window gather, bit selection, load
// ----------------------------------------------------------------------------
module rmf_ctrl #(
    parameter int HALF_WIDTH = rmf_pkg::DEF_HALF_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_action,
    input  rmf_pkg::t_sts i_sts,
    output logic        o_in_ready,
    output rmf_pkg::t_cmd o_cmd
);
    localparam int WIN   = 2 * HALF_WIDTH + 1;
    localparam int TAPS  = WIN * WIN;
    localparam int TAP_W = $clog2(TAPS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_GATHER,
        S_SELECT,
        S_LOAD
    } t_state;

    t_state                      r_state, n_state;
    logic [TAP_W-1:0]            r_tap, n_tap;
    logic [rmf_pkg::BIT_W-1:0]   r_bit, n_bit;
    logic [rmf_pkg::EMIT_W-1:0]  r_left, n_left;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_tap   = r_tap;
        n_bit   = r_bit;
        n_left  = r_left;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_in_action) begin
                        if (!i_sts.frame_pushed) begin
                            o_cmd.push = 1'b1;
                            if (i_sts.push_emits != '0) begin
                                n_left  = i_sts.push_emits;
                                n_state = S_START;
                            end
                        end
                    end else if (i_sts.frame_pushed) begin
                        n_left  = rmf_pkg::EMIT_W'(1);
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.win_start = 1'b1;
                n_tap           = '0;
                n_state         = S_GATHER;
            end
            S_GATHER: begin
                if (r_tap != TAP_W'(TAPS)) begin
                    o_cmd.win_step = 1'b1;
                    n_tap          = r_tap + 1'b1;
                end else begin
                    // last read word lands this cycle, selection starts next
                    o_cmd.sel_init = 1'b1;
                    n_bit          = rmf_pkg::BIT_W'(rmf_pkg::PIX_W - 1);
                    n_state        = S_SELECT;
                end
            end
            S_SELECT: begin
                o_cmd.sel_step = 1'b1;
                o_cmd.sel_bit  = r_bit;
                if (r_bit == '0) begin
                    n_state = S_LOAD;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = (r_left == rmf_pkg::EMIT_W'(1));
                    n_left     = r_left - 1'b1;
                    n_state    = (r_left == rmf_pkg::EMIT_W'(1)) ? S_IDLE : S_START;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
            r_bit   <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_bit   <= n_bit;
            r_left  <= n_left;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- hw/rtl/rmf_dpath.sv -----
// ----------------------------------------------------------------------------
// rmf_dpath - datapath of the median filter
// line store, position counters, window gather, radix median select, output
// ----------------------------------------------------------------------------
module rmf_dpath #(
    parameter int MAX_WIDTH  = rmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rmf_pkg::DEF_MAX_HEIGHT,
    parameter int HALF_WIDTH = rmf_pkg::DEF_HALF_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  rmf_pkg::t_reg_idx                 i_cfg_index,
    input  logic [rmf_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic [rmf_pkg::S_TDATA_W-1:0]     i_pix,
    input  rmf_pkg::t_cmd                     i_cmd,
    output rmf_pkg::t_sts                     o_sts,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [rmf_pkg::PIX_W-1:0]         o_red,
    output logic [rmf_pkg::PIX_W-1:0]         o_green,
    output logic [rmf_pkg::PIX_W-1:0]         o_blue,
    output logic [rmf_pkg::ROW_OUT_W-1:0]     o_row,
    output logic [rmf_pkg::COL_OUT_W-1:0]     o_col,
    output logic                              o_last,
    output logic                              o_frame_done
);
    localparam int WIN    = 2 * HALF_WIDTH + 1;
    localparam int TAPS   = WIN * WIN;
    localparam int MEDIAN = TAPS / 2;
    localparam int DEPTH  = WIN * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WV_W   = $clog2(MAX_WIDTH + 1);
    localparam int RW     = $clog2(MAX_HEIGHT + 1);
    localparam int MW     = $clog2(WIN);
    localparam int TI_W   = $clog2(TAPS);
    localparam int CNT_W  = $clog2(TAPS + 1);
    localparam int SC_W   = CW + 2;
    localparam int SR_W   = RW + 2;
    localparam int PW     = rmf_pkg::S_TDATA_W;
    localparam int CH_N   = rmf_pkg::CH_N;
    localparam int PIX_W  = rmf_pkg::PIX_W;

    // configuration and used frame size
    logic [rmf_pkg::WIDTH_REG_W-1:0]  r_frame_width;
    logic [rmf_pkg::HEIGHT_REG_W-1:0] r_frame_height;
    logic [WV_W-1:0]                  w_used;
    logic [RW-1:0]                    h_used;

    always_comb begin
        if (r_frame_width < rmf_pkg::WIDTH_REG_W'(HALF_WIDTH + 1)) begin
            w_used = WV_W'(HALF_WIDTH + 1);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            w_used = WV_W'(MAX_WIDTH);
        end else begin
            w_used = WV_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_used = RW'(1);
        end else if (int'(r_frame_height) > MAX_HEIGHT) begin
            h_used = RW'(MAX_HEIGHT);
        end else begin
            h_used = RW'(r_frame_height);
        end
    end

    // position counters
    logic [CW-1:0]   r_pcol, r_ecol;
    logic [RW-1:0]   r_prow, r_erow;
    logic [MW-1:0]   r_pmod, r_emod;
    logic            r_pushed;
    logic [WV_W-1:0] pc_inc, ec_inc;
    logic [RW-1:0]   pr_inc, er_inc;
    logic            frame_end;

    assign pc_inc    = WV_W'(r_pcol) + 1'b1;
    assign ec_inc    = WV_W'(r_ecol) + 1'b1;
    assign pr_inc    = r_prow + 1'b1;
    assign er_inc    = r_erow + 1'b1;
    assign frame_end = (ec_inc == w_used) && (er_inc >= h_used);

    always_comb begin
        o_sts.frame_pushed = r_pushed;
        o_sts.out_free     = !o_out_valid || i_out_ready;
        if (r_prow >= RW'(HALF_WIDTH) && r_pcol >= CW'(HALF_WIDTH)) begin
            o_sts.push_emits = (WV_W'(r_pcol) == w_used - 1'b1)
                             ? rmf_pkg::EMIT_W'(HALF_WIDTH + 1) : rmf_pkg::EMIT_W'(1);
        end else begin
            o_sts.push_emits = '0;
        end
    end

    // window walk: column offset index, row index, clamped row and its slot
    logic [MW-1:0]          r_dci, r_dri, r_wmod;
    logic [RW-1:0]          r_wrow;
    logic signed [SC_W-1:0] c_s, c_lim;
    logic [CW-1:0]          c_cl;
    logic signed [SR_W-1:0] u_s, u_lim;
    logic [RW-1:0]          nr;
    logic [AW-1:0]          rd_addr, wr_addr;

    always_comb begin
        c_s   = SC_W'(r_ecol) + SC_W'(r_dci) - SC_W'(HALF_WIDTH);
        c_lim = SC_W'(w_used) - SC_W'(1);
        if (c_s[SC_W-1]) begin
            c_cl = '0;
        end else if (c_s > c_lim) begin
            c_cl = CW'(c_lim);
        end else begin
            c_cl = CW'(c_s);
        end
        u_s   = SR_W'(r_erow) + SR_W'(r_dri) + SR_W'(1) - SR_W'(HALF_WIDTH);
        u_lim = SR_W'(h_used) - SR_W'(1);
        if (u_s[SR_W-1]) begin
            nr = '0;
        end else if (u_s > u_lim) begin
            nr = RW'(u_lim);
        end else begin
            nr = RW'(u_s);
        end
        rd_addr = AW'(int'(r_wmod) * MAX_WIDTH) + AW'(c_cl);
        wr_addr = AW'(int'(r_pmod) * MAX_WIDTH) + AW'(r_pcol);
    end

    // line store
    logic [PW-1:0] mem [DEPTH];
    logic [PW-1:0] r_rd_data;
    logic          r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[wr_addr] <= i_pix;
        end
        if (i_cmd.win_step) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= rmf_pkg::WIDTH_REG_W'(1024);
            r_frame_height <= rmf_pkg::HEIGHT_REG_W'(4096);
            r_pcol   <= '0;
            r_prow   <= '0;
            r_pmod   <= '0;
            r_ecol   <= '0;
            r_erow   <= '0;
            r_emod   <= '0;
            r_pushed <= 1'b0;
            r_rd_vld <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.win_step;
            if (i_cmd.push) begin
                if (pc_inc == w_used) begin
                    r_pcol <= '0;
                    r_prow <= pr_inc;
                    r_pmod <= (r_pmod == MW'(WIN - 1)) ? '0 : r_pmod + 1'b1;
                    if (pr_inc >= h_used) begin
                        r_pushed <= 1'b1;
                    end
                end else begin
                    r_pcol <= CW'(pc_inc);
                end
            end
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
                if (frame_end) begin
                    r_pcol   <= '0;
                    r_prow   <= '0;
                    r_pmod   <= '0;
                    r_ecol   <= '0;
                    r_erow   <= '0;
                    r_emod   <= '0;
                    r_pushed <= 1'b0;
                end else if (ec_inc == w_used) begin
                    r_ecol <= '0;
                    r_erow <= er_inc;
                    r_emod <= (r_emod == MW'(WIN - 1)) ? '0 : r_emod + 1'b1;
                end else begin
                    r_ecol <= CW'(ec_inc);
                end
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    rmf_pkg::REG_FRAME_WIDTH:
                        r_frame_width <= i_cfg_data[rmf_pkg::WIDTH_REG_W-1:0];
                    rmf_pkg::REG_FRAME_HEIGHT:
                        r_frame_height <= i_cfg_data[rmf_pkg::HEIGHT_REG_W-1:0];
                    default: ;
                endcase
                r_pcol   <= '0;
                r_prow   <= '0;
                r_pmod   <= '0;
                r_ecol   <= '0;
                r_erow   <= '0;
                r_emod   <= '0;
                r_pushed <= 1'b0;
            end
        end
    end

    // window walk and capture
    logic [TI_W-1:0] r_cap;
    logic [PW-1:0]   r_win [TAPS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.win_start) begin
            r_dci <= '0;
            r_dri <= '0;
            r_cap <= '0;
            if (r_erow >= RW'(HALF_WIDTH)) begin
                r_wrow <= r_erow - RW'(HALF_WIDTH);
                r_wmod <= (r_emod >= MW'(HALF_WIDTH)) ? r_emod - MW'(HALF_WIDTH)
                                                       : r_emod + MW'(WIN - HALF_WIDTH);
            end else begin
                r_wrow <= '0;
                r_wmod <= '0;
            end
        end else begin
            if (i_cmd.win_step) begin
                if (r_dci == MW'(WIN - 1)) begin
                    r_dci  <= '0;
                    r_dri  <= r_dri + 1'b1;
                    r_wrow <= nr;
                    if (nr != r_wrow) begin
                        r_wmod <= (r_wmod == MW'(WIN - 1)) ? '0 : r_wmod + 1'b1;
                    end
                end else begin
                    r_dci <= r_dci + 1'b1;
                end
            end
            if (r_rd_vld) begin
                r_win[r_cap] <= r_rd_data;
                r_cap        <= r_cap + 1'b1;
            end
        end
    end

    // median by bit-serial rank selection, msb first
    logic [TAPS-1:0]   r_alive [CH_N];
    logic [CNT_W-1:0]  r_rank  [CH_N];
    logic [PIX_W-1:0]  r_med   [CH_N];
    logic [TAPS-1:0]   plane   [CH_N];
    logic [CNT_W-1:0]  cnt0    [CH_N];
    logic [PIX_W-1:0]  wpix;

    always_comb begin
        for (int ch = 0; ch < CH_N; ch++) begin
            for (int j = 0; j < TAPS; j++) begin
                wpix        = r_win[j][(CH_N - 1 - ch) * PIX_W +: PIX_W];
                plane[ch][j] = wpix[i_cmd.sel_bit];
            end
            cnt0[ch] = CNT_W'($countones(r_alive[ch] & ~plane[ch]));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < CH_N; ch++) begin
            if (i_cmd.sel_init) begin
                r_alive[ch] <= '1;
                r_rank[ch]  <= CNT_W'(MEDIAN);
            end else if (i_cmd.sel_step) begin
                if (r_rank[ch] < cnt0[ch]) begin
                    r_alive[ch] <= r_alive[ch] & ~plane[ch];
                    r_med[ch][i_cmd.sel_bit] <= 1'b0;
                end else begin
                    r_alive[ch] <= r_alive[ch] & plane[ch];
                    r_rank[ch]  <= r_rank[ch] - cnt0[ch];
                    r_med[ch][i_cmd.sel_bit] <= 1'b1;
                end
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_red        <= r_med[0];
            o_green      <= r_med[1];
            o_blue       <= r_med[2];
            o_row        <= rmf_pkg::ROW_OUT_W'(r_erow);
            o_col        <= rmf_pkg::COL_OUT_W'(r_ecol);
            o_last       <= i_cmd.last;
            o_frame_done <= frame_end;
        end
    end

endmodule
